>>> src/nsp_pkg.sv
// Shared types, constants and codes of the NAL stream parser.
package nsp_pkg;

  // Byte values that steer the parser.
  localparam logic [7:0] ZeroByte  = 8'h00;
  localparam logic [7:0] StartByte = 8'h01;
  localparam logic [7:0] EppByte   = 8'h03;

  // Coded slice unit types that take part in the slice count.
  localparam logic [4:0] NalSliceNonIdr = 5'd1;
  localparam logic [4:0] NalSliceIdr    = 5'd5;

  // Register values after reset.
  localparam logic [3:0] RstSelectPeriod = 4'd3;
  localparam logic [7:0] RstWindowStart  = 8'd19;
  localparam logic [7:0] RstWindowLength = 8'd25;

  // Default depth of the command queue between front and back.
  localparam int unsigned NspQueueDepth = 2;

  typedef enum logic [1:0] {
    CfgSelectPeriod = 2'd0,
    CfgWindowStart  = 2'd1,
    CfgWindowLength = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0] select_period;
    logic [7:0] window_start;
    logic [7:0] window_length;
  } nsp_cfg_t;

  // One command: a run of zero bytes, then optionally one data byte.
  typedef struct packed {
    logic [2:0] zeros;
    logic       has_byte;
    logic [7:0] data;
    logic       first;
    logic [4:0] utype;
    logic       selected;
    logic       last_of_stream;
  } nsp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } nsp_queue_stat_t;

endpackage

>>> src/nsp_ifs.sv
// Stream channel interfaces of the NAL stream parser.
interface nsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, stream_byte, end_of_stream, input ready);
  modport sink   (input valid, stream_byte, end_of_stream, output ready);
endinterface

interface nsp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] clean_byte;
  logic       nal_first;
  logic [4:0] unit_type;
  logic       slice_selected;
  logic [7:0] byte_index;
  logic       in_window;
  logic       final_out;

  modport source (output valid, clean_byte, nal_first, unit_type, slice_selected,
                  byte_index, in_window, final_out, input ready);
  modport sink   (input valid, clean_byte, nal_first, unit_type, slice_selected,
                  byte_index, in_window, final_out, output ready);
endinterface

>>> src/nsp_front.sv
// Front end: classifies raw bytes and turns each into at most one expansion command.
module nsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  nsp_in_if.sink            stream_in,
  input  logic [3:0]        select_period_i,
  input  logic              q_full_i,
  output logic              push_o,
  output nsp_pkg::nsp_cmd_t cmd_o
);
  import nsp_pkg::*;

  logic [1:0] held_q, held_d;
  logic       inside_q, inside_d;
  logic       await_q, await_d;
  logic [4:0] type_q, type_d;
  logic       sel_q, sel_d;
  logic [3:0] phase_q, phase_d;

  logic       accept;
  logic [7:0] b;
  logic [2:0] nz;
  logic       has_byte;
  logic       first;
  logic [4:0] phase_inc;

  assign stream_in.ready = !q_full_i;
  assign accept = stream_in.valid && stream_in.ready;
  assign b = stream_in.stream_byte;
  assign phase_inc = {1'b0, phase_q} + 5'd1;

  always_comb begin
    held_d   = held_q;
    inside_d = inside_q;
    await_d  = await_q;
    type_d   = type_q;
    sel_d    = sel_q;
    phase_d  = phase_q;
    nz       = 3'd0;
    has_byte = 1'b0;
    first    = 1'b0;

    if (await_q) begin
      type_d = b[4:0];
      sel_d  = 1'b0;
      if (b[4:0] == NalSliceNonIdr || b[4:0] == NalSliceIdr) begin
        if (phase_inc >= {1'b0, select_period_i}) begin
          sel_d   = 1'b1;
          phase_d = '0;
        end else begin
          phase_d = phase_inc[3:0];
        end
      end
      has_byte = 1'b1;
      first    = 1'b1;
      held_d   = '0;
      await_d  = 1'b0;
    end else if (b == ZeroByte) begin
      if (held_q == 2'd3) begin
        if (inside_q) nz = 3'd1;
      end else begin
        held_d = held_q + 2'd1;
      end
    end else if (b == StartByte && held_q >= 2'd2) begin
      held_d   = '0;
      inside_d = 1'b1;
      await_d  = 1'b1;
    end else if (!inside_q) begin
      held_d = '0;
    end else if (b == EppByte && held_q >= 2'd2) begin
      nz     = {1'b0, held_q};
      held_d = '0;
    end else begin
      nz       = {1'b0, held_q};
      has_byte = 1'b1;
      held_d   = '0;
    end

    // At the end of the stream the zeros still held inside a unit go out too.
    if (stream_in.end_of_stream && inside_d && !await_d) begin
      nz = nz + {1'b0, held_d};
    end

    cmd_o.zeros          = nz;
    cmd_o.has_byte       = has_byte;
    cmd_o.data           = b;
    cmd_o.first          = first;
    cmd_o.utype          = type_d;
    cmd_o.selected       = sel_d;
    cmd_o.last_of_stream = stream_in.end_of_stream;

    if (stream_in.end_of_stream) begin
      held_d   = '0;
      inside_d = 1'b0;
      await_d  = 1'b0;
      type_d   = '0;
      sel_d    = 1'b0;
      phase_d  = '0;
    end
  end

  assign push_o = accept && (nz != 3'd0 || has_byte);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      inside_q <= 1'b0;
      await_q  <= 1'b0;
      type_q   <= '0;
      sel_q    <= 1'b0;
      phase_q  <= '0;
    end else if (accept) begin
      held_q   <= held_d;
      inside_q <= inside_d;
      await_q  <= await_d;
      type_q   <= type_d;
      sel_q    <= sel_d;
      phase_q  <= phase_d;
    end
  end

endmodule

>>> src/nsp_queue.sv
// Small command queue between the front end and the back end.
module nsp_queue #(
  parameter int unsigned Depth = nsp_pkg::NspQueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  nsp_pkg::nsp_cmd_t        push_cmd_i,
  input  logic                     pop_i,
  output nsp_pkg::nsp_cmd_t        head_o,
  output nsp_pkg::nsp_queue_stat_t stat_o
);
  import nsp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  nsp_cmd_t        slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop) count_q <= count_q + CntW'(1);
      else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
    end
  end

endmodule

>>> src/nsp_back.sv
// Back end: expands commands into clean bytes with index and window marks.
module nsp_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  nsp_pkg::nsp_cmd_t        head_i,
  input  nsp_pkg::nsp_queue_stat_t q_stat_i,
  input  nsp_pkg::nsp_cfg_t        cfg_i,
  output logic                     pop_o,
  nsp_out_if.source                result_out
);
  import nsp_pkg::*;

  logic [2:0] zcnt_q, zcnt_d;
  logic [7:0] pos_q, pos_d;
  logic       valid_q;
  logic [7:0] byte_q, idx_q;
  logic       first_q, sel_q, win_q, final_q;
  logic [4:0] type_q;

  logic       advance, emit_zero, last;
  logic [2:0] zcnt_inc;
  logic [7:0] idx, out_b;
  logic [8:0] win_hi;
  logic       win;

  assign advance   = !q_stat_i.empty && (!valid_q || result_out.ready);
  assign zcnt_inc  = zcnt_q + 3'd1;
  assign emit_zero = zcnt_q < head_i.zeros;
  assign last      = head_i.has_byte ? (zcnt_q == head_i.zeros) : (zcnt_inc == head_i.zeros);
  assign pop_o     = advance && last;

  always_comb begin
    out_b = emit_zero ? ZeroByte : head_i.data;
    if (!emit_zero && head_i.first) begin
      idx   = '0;
      pos_d = 8'd1;
    end else begin
      idx   = pos_q;
      pos_d = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
    end
    if (last && head_i.last_of_stream) pos_d = '0;
    zcnt_d = last ? 3'd0 : zcnt_inc;
  end

  assign win_hi = {1'b0, cfg_i.window_start} + {1'b0, cfg_i.window_length};
  assign win    = (idx >= cfg_i.window_start) && ({1'b0, idx} < win_hi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      zcnt_q  <= '0;
      pos_q   <= '0;
    end else if (advance) begin
      valid_q <= 1'b1;
      zcnt_q  <= zcnt_d;
      pos_q   <= pos_d;
    end else if (result_out.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q  <= out_b;
      first_q <= !emit_zero && head_i.first;
      type_q  <= head_i.utype;
      sel_q   <= head_i.selected;
      idx_q   <= idx;
      win_q   <= win;
      final_q <= last && head_i.last_of_stream;
    end
  end

  assign result_out.valid          = valid_q;
  assign result_out.clean_byte     = byte_q;
  assign result_out.nal_first      = first_q;
  assign result_out.unit_type      = type_q;
  assign result_out.slice_selected = sel_q;
  assign result_out.byte_index     = idx_q;
  assign result_out.in_window      = win_q;
  assign result_out.final_out      = final_q;

endmodule

>>> src/nal_stream_parse_unescape_top.sv
// Top level of the Annex B NAL stream parser with emulation prevention removal.
// The block takes one raw byte of an Annex B stream per transfer, finds 3-byte and 4-byte
// start codes, takes the byte after a start code as the NAL header, strips every 03 that
// follows two zeros inside a unit, and delivers one clean byte per output transfer tagged
// with the first-of-unit mark, unit type, slice selection, clean index and window mark.
// Bytes before the first start code are dropped, and zero bytes are held back until it is
// known whether they belong to a start code. An input byte is taken every cycle as long as
// the command queue between the front end and the back end has room; a byte that yields
// k clean bytes (k from 0 to 4, several when held zeros are released) occupies the single
// output register for k output transfers, so the rate is one input per cycle when each byte
// yields at most one result and the output takes every result, and the output register sets
// the pace in bursts of released zeros. A byte's command is held in the command queue and its
// result in the output register. Configuration writes must happen only while no transfer
// is in flight; a write to an index past the last register is ignored.
module nal_stream_parse_unescape_top #(
  parameter int unsigned QueueDepth = nsp_pkg::NspQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nsp_in_if.sink     stream_in,
  nsp_out_if.source  result_out,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);
  import nsp_pkg::*;

  // Configuration registers.
  nsp_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.select_period <= RstSelectPeriod;
      cfg_q.window_start  <= RstWindowStart;
      cfg_q.window_length <= RstWindowLength;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSelectPeriod: cfg_q.select_period <= cfg_data_i[3:0];
        CfgWindowStart:  cfg_q.window_start  <= cfg_data_i;
        CfgWindowLength: cfg_q.window_length <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front end turns each accepted byte into at most one command that the queue holds.
  nsp_cmd_t        push_cmd, head_cmd;
  logic            push, pop;
  nsp_queue_stat_t q_stat;

  nsp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .stream_in       (stream_in),
    .select_period_i (cfg_q.select_period),
    .q_full_i        (q_stat.full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  nsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .stat_o     (q_stat)
  );

  // The back end expands each command into its clean bytes, one per output transfer.
  nsp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_cmd),
    .q_stat_i   (q_stat),
    .cfg_i      (cfg_q),
    .pop_o      (pop),
    .result_out (result_out)
  );

  // A header byte always starts the clean index at zero and carries its own type.
  a_header_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_out.valid && result_out.nal_first |->
      result_out.byte_index == 8'd0 && result_out.clean_byte[4:0] == result_out.unit_type)
    else $error("header result with wrong index or type");

  // A byte inside the window never lies before its start.
  a_window_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_out.valid && result_out.in_window |-> result_out.byte_index >= cfg_q.window_start)
    else $error("window mark below window start");

  // The queue cannot be full and empty at once.
  a_queue_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

endmodule
